// File: src/ewcf_pkg.sv
// Package: widths, constants and payload types of the eye window center finder.
`timescale 1ns / 1ps
`default_nettype none
package ewcf_pkg;

  localparam int MAX_POSITIONS = 128;
  localparam int POS_W         = $clog2(MAX_POSITIONS);
  localparam int RUN_W         = 8;
  localparam int TAP_W         = 6;
  localparam int CODE_W        = 8;
  localparam int TPR_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(MAX_POSITIONS - 1);
  localparam logic [RUN_W-1:0] RUN_MAX      = '1;
  localparam logic [TPR_W-1:0] TPR_MIN      = TPR_W'(1);
  localparam logic [TPR_W-1:0] TPR_MAX      = TPR_W'(64);
  localparam logic [TPR_W-1:0] TPR_RESET    = TPR_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_PER_RANGE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DCO_MODE        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DCO_ENABLE_BITS = CFG_IDX_W'(2);

  typedef struct packed {
    logic tap_failed;
    logic last_tap;
  } tap_item_t;

  typedef struct packed {
    logic              status;
    logic [TAP_W-1:0]  best_tap;
    logic              use_inverted;
    logic [CODE_W-1:0] delay_code;
  } window_result_t;

endpackage
`default_nettype wire

// File: src/ewcf_tap_if.sv
// Interface: tap pass/fail channel.
`timescale 1ns / 1ps
`default_nettype none
interface ewcf_tap_if
  import ewcf_pkg::*;
();
  logic      valid;
  logic      ready;
  tap_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ewcf_result_if.sv
// Interface: window result channel.
`timescale 1ns / 1ps
`default_nettype none
interface ewcf_result_if
  import ewcf_pkg::*;
();
  logic           valid;
  logic           ready;
  window_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/eye_window_center_finder.sv
// Top level: longest passing run tracker and window center result.
//
//  channel    dir  transfer when         payload
//  tap_ch_i   in   valid & ready         tap_failed, last_tap
//  res_ch_o   out  valid & ready         status, best_tap, use_inverted, delay_code
//  cfg_*_i    in   cfg_we_i high         cfg_idx_i, cfg_wdata_i
//
// One tap per cycle sustained. Run tracking updates in the cycle of the transfer;
// a last tap latches the final best run into a hold stage, and once the result
// register is free the midpoint, range split and delay code are formed into it.
// Reset clears sweep state and loads register defaults (32 taps, plain mode).
// A stalled result blocks taps only once the hold stage is also full.
`timescale 1ns / 1ps
`default_nettype none
module eye_window_center_finder
  import ewcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ewcf_tap_if.sink                   tap_ch_i,
  ewcf_result_if.source              res_ch_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [TPR_W-1:0]  taps_per_range_q;
  logic              dco_mode_q;
  logic [CODE_W-1:0] dco_enable_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_per_range_q  <= TPR_RESET;
      dco_mode_q        <= 1'b0;
      dco_enable_bits_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAPS_PER_RANGE:  taps_per_range_q  <= cfg_wdata_i[TPR_W-1:0];
        CFG_DCO_MODE:        dco_mode_q        <= cfg_wdata_i[0];
        CFG_DCO_ENABLE_BITS: dco_enable_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sweep state
  logic [POS_W-1:0] position_q, position_d;
  logic [POS_W-1:0] run_start_q, run_start_d;
  logic [RUN_W-1:0] run_length_q, run_length_d;
  logic [POS_W-1:0] best_start_q, best_start_d;
  logic [RUN_W-1:0] best_length_q, best_length_d;

  // hold stage: final best run of a finished sweep
  logic             hold_valid_q;
  logic [POS_W-1:0] hold_start_q;
  logic [RUN_W-1:0] hold_length_q;

  logic             res_valid_q;
  window_result_t   res_q, res_d;

  logic tap_xfer, res_free, hold_adv;

  assign res_free        = !res_valid_q || res_ch_o.ready;
  assign hold_adv        = hold_valid_q && res_free;
  assign tap_ch_i.ready  = !hold_valid_q || hold_adv;
  assign tap_xfer        = tap_ch_i.valid && tap_ch_i.ready;

  // run tracking for the current tap
  logic [POS_W-1:0] upd_run_start, fin_start;
  logic [RUN_W-1:0] upd_run_length, fin_length;
  logic [POS_W-1:0] upd_best_start;
  logic [RUN_W-1:0] upd_best_length;

  always_comb begin
    upd_run_start   = run_start_q;
    upd_run_length  = run_length_q;
    upd_best_start  = best_start_q;
    upd_best_length = best_length_q;
    if (!tap_ch_i.data.tap_failed) begin
      if (run_length_q == '0) upd_run_start = position_q;
      if (run_length_q != RUN_MAX) upd_run_length = run_length_q + RUN_W'(1);
    end else begin
      // failing tap closes the run; strictly longer wins
      if (run_length_q > best_length_q) begin
        upd_best_length = run_length_q;
        upd_best_start  = run_start_q;
      end
      upd_run_length = '0;
    end

    // close of the open run at sweep end
    fin_start  = upd_best_start;
    fin_length = upd_best_length;
    if (upd_run_length > upd_best_length) begin
      fin_start  = upd_run_start;
      fin_length = upd_run_length;
    end

    position_d    = position_q;
    run_start_d   = run_start_q;
    run_length_d  = run_length_q;
    best_start_d  = best_start_q;
    best_length_d = best_length_q;
    if (tap_xfer) begin
      if (tap_ch_i.data.last_tap) begin
        position_d    = '0;
        run_start_d   = '0;
        run_length_d  = '0;
        best_start_d  = '0;
        best_length_d = '0;
      end else begin
        position_d    = (position_q != POS_LAST) ? position_q + POS_W'(1) : position_q;
        run_start_d   = upd_run_start;
        run_length_d  = upd_run_length;
        best_start_d  = upd_best_start;
        best_length_d = upd_best_length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      run_start_q   <= '0;
      run_length_q  <= '0;
      best_start_q  <= '0;
      best_length_q <= '0;
      hold_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      position_q    <= position_d;
      run_start_q   <= run_start_d;
      run_length_q  <= run_length_d;
      best_start_q  <= best_start_d;
      best_length_q <= best_length_d;
      if (tap_xfer && tap_ch_i.data.last_tap) hold_valid_q <= 1'b1;
      else if (hold_adv)                      hold_valid_q <= 1'b0;
      if (hold_adv)      res_valid_q <= 1'b1;
      else if (res_free) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_xfer && tap_ch_i.data.last_tap) begin
      hold_start_q  <= fin_start;
      hold_length_q <= fin_length;
    end
    if (hold_adv) res_q <= res_d;
  end

  // midpoint, range split and delay code
  logic [TPR_W-1:0]  range_n;
  logic [RUN_W-1:0]  mid, over;
  logic [TAP_W-1:0]  tap;
  logic              inv;

  always_comb begin
    range_n = taps_per_range_q;
    if (range_n < TPR_MIN) range_n = TPR_MIN;
    if (range_n > TPR_MAX) range_n = TPR_MAX;

    mid  = RUN_W'(hold_start_q) + (hold_length_q >> 1);
    over = mid - RUN_W'(range_n);
    if (mid < RUN_W'(range_n)) begin
      tap = mid[TAP_W-1:0];
      inv = 1'b0;
    end else begin
      inv = 1'b1;
      // saturate past the inverted range
      if (over >= RUN_W'(range_n)) tap = TAP_W'(range_n - TPR_W'(1));
      else                         tap = over[TAP_W-1:0];
    end

    res_d = '0;
    if (hold_length_q == '0) begin
      res_d.status = 1'b1;
    end else begin
      res_d.best_tap     = tap;
      res_d.use_inverted = inv;
      if (!dco_mode_q)    res_d.delay_code = CODE_W'(tap);
      else if (tap != '0) res_d.delay_code = CODE_W'(tap - TAP_W'(1)) | dco_enable_bits_q;
      else                res_d.delay_code = '0;
    end
  end

  assign res_ch_o.valid = res_valid_q;
  assign res_ch_o.data  = res_q;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_xfer && tap_ch_i.data.last_tap |=> position_q == '0 && best_length_q == '0
      && run_length_q == '0)
    else $error("sweep state not cleared after last tap");

  a_hold_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q && !res_free |=> hold_valid_q && $stable(hold_length_q))
    else $error("held sweep result lost while output stalled");

  a_no_pass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status |-> res_q.best_tap == '0 && !res_q.use_inverted
      && res_q.delay_code == '0)
    else $error("no-pass result carries a tap");

  a_plain_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.status && !dco_mode_q |-> res_q.delay_code == CODE_W'(res_q.best_tap))
    else $error("plain delay code differs from tap");
`endif

endmodule
`default_nettype wire
